// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the decoder RTL. Empty bodies when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold on every clock edge outside reset
`define OBUD_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define OBUD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define OBUD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define OBUD_ASSERT_HOLDS(lbl, clk, rst, cond, msg)
`define OBUD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define OBUD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/core/obud_pkg.sv =====
`default_nettype none

package obud_pkg;

  // Character codes
  localparam logic [7:0] BSLASH   = 8'h5C;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  // Decoded bytes one input can produce, and width of that count
  localparam int JOB_SLOTS = 3;
  localparam int JOB_CNT_W = 2;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

  // Escape tracking in the front
  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,  // normal text
    PH_ESC  = 2'd1,  // after backslash
    PH_DIG1 = 2'd2,  // after backslash and one digit 0-3
    PH_DIG2 = 2'd3   // after backslash and two digits
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic        is_summary;
    logic [7:0]  data_byte;
    logic [15:0] decoded_length;
    logic        run_last;
  } out_item_t;

  // One classified input: candidate data bytes in order, plus end-of-text report
  typedef struct packed {
    logic [JOB_SLOTS-1:0][7:0] data;
    logic [JOB_CNT_W-1:0]      cnt;
    logic                      summary;
  } job_t;

  // Character of a held octal digit
  function automatic logic [7:0] digit_char(input logic [2:0] d);
    digit_char = CHAR_ZERO | {5'b0, d};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/obud_front.sv =====
`default_nettype none

module obud_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire obud_pkg::in_item_t in_item,
  input  wire logic              q_full,
  output logic                   push,
  output obud_pkg::job_t         push_job
);
  import obud_pkg::*;

  phase_t     phase, phase_next, step_phase;
  logic [1:0] held_a, held_a_next, step_a;
  logic [2:0] held_b, held_b_next, step_b;
  logic       accept;
  logic [7:0] b;
  logic       is_bs, is_oct, is_low;
  logic [JOB_CNT_W-1:0] n;
  job_t       job;

  assign b      = in_item.text_byte;
  assign is_bs  = (b == BSLASH);
  assign is_oct = (b[7:3] == 5'b00110);
  assign is_low = (b[7:2] == 6'b001100);

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Escape phase after this character, before end-of-text handling
  always_comb begin
    step_phase = phase;
    step_a     = held_a;
    step_b     = held_b;
    unique case (phase)
      PH_TEXT: begin
        if (is_bs) step_phase = PH_ESC;
      end
      PH_ESC: begin
        if (is_bs) begin
          step_phase = PH_TEXT;
        end else if (is_low) begin
          step_a     = b[1:0];
          step_phase = PH_DIG1;
        end else begin
          step_phase = PH_TEXT;
        end
      end
      PH_DIG1: begin
        if (is_oct) begin
          step_b     = b[2:0];
          step_phase = PH_DIG2;
        end else begin
          step_phase = is_bs ? PH_ESC : PH_TEXT;
        end
      end
      PH_DIG2: begin
        step_phase = (!is_oct && is_bs) ? PH_ESC : PH_TEXT;
      end
      default: step_phase = PH_TEXT;
    endcase
  end

  // Next state: end of text returns to normal text
  always_comb begin
    phase_next  = phase;
    held_a_next = held_a;
    held_b_next = held_b;
    if (accept) begin
      if (in_item.end_of_text) begin
        phase_next  = PH_TEXT;
        held_a_next = '0;
        held_b_next = '0;
      end else begin
        phase_next  = step_phase;
        held_a_next = step_a;
        held_b_next = step_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_TEXT;
      held_a <= '0;
      held_b <= '0;
    end else begin
      phase  <= phase_next;
      held_a <= held_a_next;
      held_b <= held_b_next;
    end
  end

  // Outputs: list of decoded bytes for this character
  always_comb begin
    job = '0;
    n   = '0;
    unique case (phase)
      PH_TEXT: begin
        if (!is_bs) begin
          job.data[n] = b;
          n = n + 1'b1;
        end
      end
      PH_ESC: begin
        if (is_bs) begin
          job.data[n] = BSLASH;
          n = n + 1'b1;
        end else if (!is_low) begin
          job.data[n] = b;
          n = n + 1'b1;
        end
      end
      PH_DIG1: begin
        if (!is_oct) begin
          job.data[n] = digit_char({1'b0, held_a});
          n = n + 1'b1;
          if (!is_bs) begin
            job.data[n] = b;
            n = n + 1'b1;
          end
        end
      end
      PH_DIG2: begin
        if (is_oct) begin
          job.data[n] = {held_a, held_b, b[2:0]};
          n = n + 1'b1;
        end else begin
          job.data[n] = digit_char({1'b0, held_a});
          n = n + 1'b1;
          job.data[n] = digit_char(held_b);
          n = n + 1'b1;
          if (!is_bs) begin
            job.data[n] = b;
            n = n + 1'b1;
          end
        end
      end
      default: n = '0;
    endcase
    // held digits at end of text go out as characters; a lone backslash is dropped
    if (in_item.end_of_text) begin
      if (step_phase == PH_DIG1) begin
        job.data[n] = digit_char({1'b0, step_a});
        n = n + 1'b1;
      end else if (step_phase == PH_DIG2) begin
        job.data[n] = digit_char({1'b0, step_a});
        n = n + 1'b1;
        job.data[n] = digit_char(step_b);
        n = n + 1'b1;
      end
    end
    job.cnt     = n;
    job.summary = in_item.end_of_text;
  end

  // Only characters that produce something enter the queue
  assign push     = accept && ((job.cnt != '0) || job.summary);
  assign push_job = job;

endmodule

`default_nettype wire

// ===== rtl/core/obud_queue.sv =====
`default_nettype none

module obud_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire obud_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                head_valid,
  output obud_pkg::job_t      head
);
  import obud_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/obud_back.sv =====
`default_nettype none
`include "assert_macros.svh"

module obud_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_data,
  input  wire logic              head_valid,
  input  wire obud_pkg::job_t    head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output obud_pkg::out_item_t    out_item
);
  import obud_pkg::*;

  logic [15:0]          capacity;
  logic [15:0]          produced_count, produced_count_next;
  logic                 overflowed, overflowed_next;
  logic [JOB_CNT_W-1:0] idx, idx_next;
  logic [16:0]          count_plus1;
  logic                 advance, load, last_data, room;
  out_item_t            res;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  assign advance     = !out_valid || out_ready;
  assign count_plus1 = {1'b0, produced_count} + 17'd1;
  assign room        = (produced_count < capacity);
  assign last_data   = (idx == head.cnt - 1'b1);

  // Walk the head job one result per cycle while the output register can advance
  always_comb begin
    load                = 1'b0;
    pop                 = 1'b0;
    res                 = '0;
    idx_next            = idx;
    produced_count_next = produced_count;
    overflowed_next     = overflowed;
    if (head_valid && advance) begin
      if (idx < head.cnt) begin
        if (room) begin
          load                = 1'b1;
          res.data_byte       = head.data[idx];
          produced_count_next = count_plus1[15:0];
          // later bytes of this job find no room once the count reaches capacity
          res.run_last = !head.summary &&
                         (last_data || (count_plus1 >= {1'b0, capacity}));
          if (last_data && !head.summary) begin
            pop      = 1'b1;
            idx_next = '0;
          end else begin
            idx_next = idx + 1'b1;
          end
        end else begin
          // no room: rest of the data is dropped
          overflowed_next = 1'b1;
          pop             = 1'b1;
          idx_next        = '0;
          if (head.summary) begin
            load                = 1'b1;
            res.is_summary      = 1'b1;
            res.run_last        = 1'b1;
            produced_count_next = '0;
            overflowed_next     = 1'b0;
          end
        end
      end else begin
        // length report closes the text
        load                = 1'b1;
        res.is_summary      = 1'b1;
        res.decoded_length  = overflowed ? 16'd0 : produced_count;
        res.run_last        = 1'b1;
        produced_count_next = '0;
        overflowed_next     = 1'b0;
        pop                 = 1'b1;
        idx_next            = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx            <= '0;
      produced_count <= '0;
      overflowed     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      idx            <= idx_next;
      produced_count <= produced_count_next;
      overflowed     <= overflowed_next;
      if (advance) out_valid <= load;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) out_item <= res;
  end

  `OBUD_ASSERT_IMPLIES(a_head_has_work, clk, rst, head_valid, (idx < head.cnt) || head.summary, "head job has nothing left to do")
  `OBUD_ASSERT_IMPLIES(a_data_no_length, clk, rst, out_valid && !out_item.is_summary, out_item.decoded_length == 16'd0, "data result carries a length")
  `OBUD_ASSERT_IMPLIES(a_report_is_last, clk, rst, out_valid && out_item.is_summary, out_item.run_last, "length report not marked last")
  `OBUD_ASSERT_NEXT(a_report_clears, clk, rst, load && res.is_summary, (produced_count == 16'd0) && !overflowed && (idx == '0), "text state not cleared after report")

endmodule

`default_nettype wire

// ===== rtl/core/octal_backslash_unescape_decoder_top.sv =====
// A character's results pass from the front through a queue entry and then the output register.
// Throughput: one character per cycle while each yields at most one result and out_ready is
// high; the result register emits one result per cycle, so a character with k results (k up
// to 4) holds it until all k have gone out.
// When no room is left, the rest of a job with no report behind it is dropped with no result.
// Reset (synchronous rst): escape state, counts and queue clear; capacity returns to 65535.
`default_nettype none

module octal_backslash_unescape_decoder_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire obud_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output obud_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_data
);
  import obud_pkg::*;

  logic q_full, push, pop, head_valid;
  job_t push_job, head;

  // Classify characters into decoded-byte jobs
  obud_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Decouple classification from emission
  obud_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Capacity check, counting and result output
  obud_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire
